FILE: rtl/lbt_pkg.sv
// Shared types and constants of the level-of-detail blend tracker.
`timescale 1ns / 1ps
package lbt_pkg;

  // Input function codes
  localparam logic [2:0] FUNC_REGISTER   = 3'd0;
  localparam logic [2:0] FUNC_UNREGISTER = 3'd1;
  localparam logic [2:0] FUNC_CLEAR_ALL  = 3'd2;
  localparam logic [2:0] FUNC_SET_TARGET = 3'd3;
  localparam logic [2:0] FUNC_TICK       = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_BLENDING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_DURATION  = 2'd1;

  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned FACTOR_W  = 17;
  localparam int unsigned QUOT_W    = 16;
  localparam int unsigned MTERM_W   = 18;

  localparam logic [FACTOR_W-1:0]  ONE_Q16     = 17'd65536;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 24'hFFFFFF;
  localparam logic [MTERM_W-1:0]   THREE_Q16   = 18'd196608;
  localparam logic [ELAPSED_W-1:0] DURATION_RST = 24'd250000;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  object_id;
    logic [2:0]  target_lod;
    logic [15:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  slot_id;
    logic [2:0]  current_level;
    logic [2:0]  goal_level;
    logic        is_blending;
    logic [16:0] blend_factor;
    logic        change_event;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_CLEAR_SLOT,
    OP_CLEAR_ALL,
    OP_SET,
    OP_TICK,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         slot;
    logic               slot_ok;
    logic [LEVEL_W-1:0] target;
    logic [DELTA_W-1:0] delta;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   shown;
    logic [LEVEL_W-1:0]   wanted;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 active;
  } rec_t;

  typedef struct packed {
    logic                 enable;
    logic [ELAPSED_W-1:0] duration;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_READ,
    ST_MODIFY,
    ST_WEIGHT,
    ST_RESP
  } back_state_e;

  typedef enum logic [1:0] {
    W_IDLE,
    W_DIV,
    W_SQ,
    W_MUL
  } wgt_state_e;

endpackage

FILE: rtl/lbt_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module lbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lbt_front.sv
// Front end: accept input beats, classify them and queue commands.
`timescale 1ns / 1ps
module lbt_front
  import lbt_pkg::*;
#(
  parameter int unsigned OBJECT_SLOTS = 256,
  parameter int unsigned LOD_LEVELS   = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     hold_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_new;
  logic       push;

  // Classify the incoming beat
  always_comb begin
    cmd_new.slot    = in_data_i.object_id;
    cmd_new.slot_ok = int'(in_data_i.object_id) < OBJECT_SLOTS;
    cmd_new.delta   = in_data_i.delta_time;
    cmd_new.target  = in_data_i.target_lod;
    if (int'(in_data_i.target_lod) > LOD_LEVELS - 1) begin
      cmd_new.target = LEVEL_W'(LOD_LEVELS - 1);
    end
    if (in_data_i.func inside {FUNC_REGISTER, FUNC_UNREGISTER}) begin
      cmd_new.op = OP_CLEAR_SLOT;
    end else begin
      case (in_data_i.func)
        FUNC_CLEAR_ALL:  cmd_new.op = OP_CLEAR_ALL;
        FUNC_SET_TARGET: cmd_new.op = OP_SET;
        FUNC_TICK:       cmd_new.op = OP_TICK;
        default:         cmd_new.op = OP_QUERY;
      endcase
    end
  end

  assign in_ready_o  = (count_q != 2'd2) && !hold_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = count_q != 2'd0;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/lbt_weight.sv
// Smoothstep weight unit: bit-serial divide, then two registered multiplies.
`timescale 1ns / 1ps
module lbt_weight
  import lbt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 active_i,
  input  logic [ELAPSED_W-1:0] elapsed_i,
  input  logic [ELAPSED_W-1:0] duration_i,
  output logic                 done_o,
  output logic [FACTOR_W-1:0]  factor_o
);

  wgt_state_e state_q, state_d;
  logic [3:0]           step_q, step_d;
  logic                 done_q, done_d;
  logic [ELAPSED_W-1:0] rem_q, rem_d, dur_q, dur_d;
  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic [31:0]          sq_q, sq_d;
  logic [MTERM_W-1:0]   mterm_q, mterm_d;
  logic [FACTOR_W-1:0]  factor_q, factor_d;
  logic [ELAPSED_W:0]   rem_sh;
  logic                 ge;
  logic [49:0]          prod;

  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, dur_q};
  assign prod   = sq_q * mterm_q;

  // Next state: one quotient bit a cycle, then square, then scale
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    done_d   = 1'b0;
    rem_d    = rem_q;
    dur_d    = dur_q;
    quot_d   = quot_q;
    sq_d     = sq_q;
    mterm_d  = mterm_q;
    factor_d = factor_q;
    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          if (!active_i || elapsed_i >= duration_i) begin
            factor_d = ONE_Q16;
            done_d   = 1'b1;
          end else begin
            rem_d   = elapsed_i;
            dur_d   = duration_i;
            step_d  = 4'd0;
            state_d = W_DIV;
          end
        end
      end
      W_DIV: begin
        rem_d  = ge ? ELAPSED_W'(rem_sh - {1'b0, dur_q}) : rem_sh[ELAPSED_W-1:0];
        quot_d = {quot_q[QUOT_W-2:0], ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          state_d = W_SQ;
        end
      end
      W_SQ: begin
        sq_d    = quot_q * quot_q;
        mterm_d = THREE_Q16 - {1'b0, quot_q, 1'b0};
        state_d = W_MUL;
      end
      W_MUL: begin
        factor_d = prod[32 +: FACTOR_W];
        done_d   = 1'b1;
        state_d  = W_IDLE;
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    rem_q    <= rem_d;
    dur_q    <= dur_d;
    quot_q   <= quot_d;
    sq_q     <= sq_d;
    mterm_q  <= mterm_d;
    factor_q <= factor_d;
  end

  assign done_o   = done_q;
  assign factor_o = factor_q;

endmodule

FILE: rtl/lbt_back.sv
// Back end: sequencer over the slot table, sweeps, weight and result register.
`timescale 1ns / 1ps
module lbt_back
  import lbt_pkg::*;
#(
  parameter int unsigned OBJECT_SLOTS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      boot_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(OBJECT_SLOTS);
  localparam logic [AW:0] LAST = (AW+1)'(OBJECT_SLOTS - 1);
  localparam logic [AW:0] ENDC = (AW+1)'(OBJECT_SLOTS);

  back_state_e state_q, state_d;
  logic [AW:0]         cnt_q, cnt_d;
  logic                reply_q, reply_d;
  logic                out_valid_q, out_valid_d;
  cmd_t                cmd_q, cmd_d;
  rec_t                rec_q, rec_d;
  logic [FACTOR_W-1:0] factor_q, factor_d;
  logic                event_q, event_d;
  out_item_t           out_q, out_d;

  logic          we;
  logic [AW-1:0] waddr, raddr, slot_idx;
  rec_t          wdata, rdata, upd;
  logic          wgt_start, wgt_done;
  logic [FACTOR_W-1:0] wgt_factor;
  logic [ELAPSED_W:0]  sum;

  assign slot_idx = AW'(cmd_q.slot);

  lbt_ram #(.WIDTH($bits(rec_t)), .DEPTH(OBJECT_SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lbt_weight u_weight (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (wgt_start),
    .active_i   (rec_q.active),
    .elapsed_i  (rec_q.elapsed),
    .duration_i (cfg_i.duration),
    .done_o     (wgt_done),
    .factor_o   (wgt_factor)
  );

  // Advance one record by the tick's delta
  always_comb begin
    upd = rdata;
    sum = {1'b0, rdata.elapsed} + {{(ELAPSED_W + 1 - DELTA_W){1'b0}}, cmd_q.delta};
    if (rdata.active) begin
      upd.elapsed = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
      if (upd.elapsed >= cfg_i.duration) begin
        upd.shown  = rdata.wanted;
        upd.active = 1'b0;
      end
    end
  end

  // Sequence one command at a time
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    reply_d     = reply_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_d       = cmd_q;
    rec_d       = rec_q;
    factor_d    = factor_q;
    event_d     = event_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = slot_idx;
    wdata       = '0;
    raddr       = slot_idx;
    wgt_start   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          rec_d    = '0;
          factor_d = ONE_Q16;
          event_d  = 1'b0;
          reply_d  = 1'b0;
          state_d  = reply_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          cnt_d   = '0;
          rec_d   = '0;
          event_d = 1'b0;
          factor_d = ONE_Q16;
          case (cmd_i.op)
            OP_CLEAR_ALL: begin
              reply_d = 1'b1;
              state_d = ST_CLEAR;
            end
            OP_TICK: state_d = ST_TICK;
            default: state_d = cmd_i.slot_ok ? ST_READ : ST_RESP;
          endcase
        end
      end
      ST_TICK: begin
        // read slot cnt while writing back slot cnt-1
        raddr = cnt_q[AW-1:0];
        if (cnt_q != '0) begin
          we    = 1'b1;
          waddr = AW'(cnt_q - 1'b1);
          wdata = upd;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ENDC) begin
          state_d = cmd_q.slot_ok ? ST_READ : ST_RESP;
        end
      end
      ST_READ: begin
        cnt_d   = '0;
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        rec_d = rdata;
        case (cmd_q.op)
          OP_CLEAR_SLOT: rec_d = '0;
          OP_SET: begin
            if (cmd_q.target != rdata.shown) begin
              rec_d.wanted = cmd_q.target;
              if (cfg_i.enable) begin
                rec_d.elapsed = '0;
                rec_d.active  = 1'b1;
                event_d       = 1'b1;
              end else begin
                rec_d.shown  = cmd_q.target;
                rec_d.active = 1'b0;
              end
            end
          end
          default: rec_d = rdata;
        endcase
        we      = 1'b1;
        wdata   = rec_d;
        state_d = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        wgt_start = 1'b1;
        state_d   = ST_RESP;
        cnt_d     = '0;
        // wait for the weight unit
        state_d   = ST_WEIGHT;
        if (cnt_q != '0) begin
          wgt_start = 1'b0;
        end
        cnt_d = (AW+1)'(1);
        if (wgt_done) begin
          factor_d = wgt_factor;
          state_d  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.slot_id       = cmd_q.slot;
          out_d.current_level = rec_q.shown;
          out_d.goal_level    = rec_q.wanted;
          out_d.is_blending   = rec_q.active;
          out_d.blend_factor  = factor_q;
          out_d.change_event  = event_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      reply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      reply_q     <= reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rec_q    <= rec_d;
    factor_q <= factor_d;
    event_q  <= event_d;
    out_q    <= out_d;
  end

  assign boot_o      = (state_q == ST_CLEAR) && !reply_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/lod_blend_tracker_unit.sv
// Top level of the level-of-detail blend tracker.
//
//   channel | direction | handshake             | beat
//   in      | input     | in_valid_i/in_ready_o | in_data_i (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// After reset a clearing pass writes every slot, with input closed.
// Per-slot items pass the read, modify and weight states into the result register; the
// weight unit runs its bit-serial divider and then the multiplies while blending.
// Tick sweeps the slot table, then the addressed slot is reported; clear all rewrites
// every slot before its result is reported.
// A two-beat command queue lets input beats land while the back end or a stalled
// output holds; the result register frees the back end once a beat is taken.
`timescale 1ns / 1ps
module lod_blend_tracker_unit
  import lbt_pkg::*;
#(
  parameter int unsigned OBJECT_SLOTS = 256,
  parameter int unsigned LOD_LEVELS   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ELAPSED_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid, pop, boot;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= 1'b1;
      cfg_q.duration <= DURATION_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLE_BLENDING: cfg_q.enable   <= cfg_data_i[0];
        REG_BLEND_DURATION:  cfg_q.duration <= cfg_data_i;
        default:             cfg_q          <= cfg_q;
      endcase
    end
  end

  lbt_front #(.OBJECT_SLOTS(OBJECT_SLOTS), .LOD_LEVELS(LOD_LEVELS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (boot),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .pop_i       (pop)
  );

  lbt_back #(.OBJECT_SLOTS(OBJECT_SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .boot_o      (boot),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A started blend is always reported as blending
  a_event_blending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.change_event |-> out_data_o.is_blending)
    else $error("change event without blending");

  // A settled record always reports full weight
  a_idle_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_blending |-> out_data_o.blend_factor == ONE_Q16)
    else $error("weight not one outside a blend");

  // No item enters during the clearing pass after reset
  a_boot_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    boot |-> !in_ready_o)
    else $error("input open during clearing pass");

endmodule

FILE: tb/sv/lbt_result_checker.sv
// Checker for the blend tracker: tracks slot records, predicts and compares each result beat.
`timescale 1ns / 1ps
module lbt_result_checker
  import lbt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ELAPSED_W-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int unsigned SLOTS = 256;
  localparam int unsigned TOP_LEVEL = 7;

  logic [2:0]  shown_q [SLOTS];
  logic [2:0]  wanted_q [SLOTS];
  logic [23:0] elapsed_q [SLOTS];
  logic        active_q [SLOTS];
  logic        blend_en_q;
  logic [23:0] duration_q;
  out_item_t   record_queue [$];

  assign pending_o = record_queue.size();

  // Smoothstep weight of one slot in Q1.16
  function automatic logic [16:0] slot_weight(int unsigned s);
    longint unsigned e, d, t;
    if (!active_q[s]) return ONE_Q16;
    e = elapsed_q[s];
    d = duration_q;
    if (e >= d) return ONE_Q16;
    t = (e << 16) / d;
    if (t > 65536) t = 65536;
    return 17'((t * t * (196608 - 2 * t)) >> 32);
  endfunction

  // Advance the record table by one command and return the reported record
  function automatic out_item_t track_command(in_item_t cmd);
    out_item_t   res;
    logic [2:0]  tgt;
    int unsigned s;
    logic [24:0] sum;
    s   = cmd.object_id;
    tgt = cmd.target_lod > TOP_LEVEL ? 3'(TOP_LEVEL) : cmd.target_lod;
    res = '0;
    case (cmd.func)
      FUNC_REGISTER, FUNC_UNREGISTER: begin
        shown_q[s] = 0; wanted_q[s] = 0; elapsed_q[s] = 0; active_q[s] = 0;
      end
      FUNC_CLEAR_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          shown_q[i] = 0; wanted_q[i] = 0; elapsed_q[i] = 0; active_q[i] = 0;
        end
      end
      FUNC_SET_TARGET: begin
        if (tgt != shown_q[s]) begin
          if (blend_en_q) begin
            wanted_q[s] = tgt; elapsed_q[s] = 0; active_q[s] = 1;
            res.change_event = 1'b1;
          end else begin
            shown_q[s] = tgt; wanted_q[s] = tgt; active_q[s] = 0;
          end
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (active_q[i]) begin
            sum = elapsed_q[i] + cmd.delta_time;
            elapsed_q[i] = sum > ELAPSED_MAX ? ELAPSED_MAX : sum[23:0];
            if (elapsed_q[i] >= duration_q) begin
              shown_q[i] = wanted_q[i];
              active_q[i] = 0;
            end
          end
        end
      end
      default: ;
    endcase
    res.slot_id       = cmd.object_id;
    res.current_level = shown_q[s];
    res.goal_level    = wanted_q[s];
    res.is_blending   = active_q[s];
    res.blend_factor  = slot_weight(s);
    return res;
  endfunction

  // Watch the channels, predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        shown_q[i] = 0; wanted_q[i] = 0; elapsed_q[i] = 0; active_q[i] = 0;
      end
      blend_en_q    = 1'b1;
      duration_q    = DURATION_RST;
      fail_count_o <= 0;
      record_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_ENABLE_BLENDING) blend_en_q = cfg_data_i[0];
        else if (cfg_index_i == REG_BLEND_DURATION) duration_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (record_queue.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = record_queue.pop_front();
          if (want != out_data_i) begin
            if (want.slot_id != out_data_i.slot_id)
              $error("slot_id: expected %0d, got %0d", want.slot_id, out_data_i.slot_id);
            if (want.current_level != out_data_i.current_level)
              $error("current_level: expected %0d, got %0d",
                     want.current_level, out_data_i.current_level);
            if (want.goal_level != out_data_i.goal_level)
              $error("goal_level: expected %0d, got %0d",
                     want.goal_level, out_data_i.goal_level);
            if (want.is_blending != out_data_i.is_blending)
              $error("is_blending: expected %0d, got %0d",
                     want.is_blending, out_data_i.is_blending);
            if (want.blend_factor != out_data_i.blend_factor)
              $error("blend_factor: expected %0d, got %0d",
                     want.blend_factor, out_data_i.blend_factor);
            if (want.change_event != out_data_i.change_event)
              $error("change_event: expected %0d, got %0d",
                     want.change_event, out_data_i.change_event);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        record_queue.insert(record_queue.size(), track_command(in_data_i));
    end
  end

endmodule

FILE: tb/sv/tb_lod_blend_tracker_unit.sv
// Testbench top for the blend tracker: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_lod_blend_tracker_unit;
  import lbt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] FUNC_QUERY = 3'd5;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ELAPSED_W-1:0] cfg_data_i = '0;
  int                   fail_count;
  int                   pending;
  int                   items_sent = 0;
  int                   phases_run = 0;
  int                   idle_cycles = 0;
  bit                   calm_mode = 1'b0;
  bit                   hold_sink = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lod_blend_tracker_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  lbt_result_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: count cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts, long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        out_ready_i <= 1'b0;
        while (hold_sink) @(posedge clk_i);
      end else if (!calm_mode && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(logic [2:0] fn, logic [7:0] id, logic [2:0] lvl, logic [15:0] dt);
    int n;
    bit ok;
    if (!calm_mode && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{func: fn, object_id: id, target_lod: lvl, delta_time: dt};
    // sample ready between edges, where it is stable
    do begin
      @(negedge clk_i);
      ok = in_ready_o;
      @(posedge clk_i);
    end while (!ok);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ELAPSED_W-1:0] val);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic on a small set of slots so blends overlap and complete
  task automatic random_phase(int count, logic [15:0] dt_max);
    logic [2:0] fn;
    logic [7:0] id;
    int         r;
    repeat (count) begin
      r  = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      if (r < 40)      fn = FUNC_SET_TARGET;
      else if (r < 62) fn = FUNC_TICK;
      else if (r < 82) fn = FUNC_QUERY;
      else if (r < 90) fn = FUNC_REGISTER;
      else if (r < 95) fn = FUNC_UNREGISTER;
      else if (r < 97) fn = FUNC_CLEAR_ALL;
      else             fn = 3'($urandom_range(6, 7));
      send_item(fn, id, 3'($urandom), ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                                   : 16'($urandom_range(0, dt_max)));
    end
    drain_results();
    phases_run++;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (300) @(posedge clk_i);

    // Directed: extremes, every function, the special cases
    send_item(FUNC_SET_TARGET, 8'd0, 3'd7, 16'd0);
    send_item(FUNC_QUERY, 8'd0, 3'd0, 16'd0);
    send_item(FUNC_SET_TARGET, 8'd0, 3'd0, 16'd0);     // equal to shown level mid-blend
    send_item(FUNC_TICK, 8'd0, 3'd0, 16'd65535);
    send_item(FUNC_TICK, 8'd255, 3'd7, 16'd0);
    send_item(FUNC_TICK, 8'd0, 3'd0, 16'd65535);
    send_item(FUNC_TICK, 8'd0, 3'd0, 16'd65535);
    send_item(FUNC_TICK, 8'd0, 3'd0, 16'd65535);
    send_item(FUNC_SET_TARGET, 8'd255, 3'd5, 16'hFFFF);
    send_item(3'd6, 8'd255, 3'd0, 16'd0);
    send_item(3'd7, 8'd255, 3'd7, 16'hAAAA);
    send_item(FUNC_UNREGISTER, 8'd255, 3'd0, 16'd0);
    send_item(FUNC_SET_TARGET, 8'd9, 3'd3, 16'h5555);
    send_item(FUNC_REGISTER, 8'd9, 3'd0, 16'd0);
    send_item(FUNC_SET_TARGET, 8'd10, 3'd2, 16'd0);
    send_item(FUNC_CLEAR_ALL, 8'd10, 3'd0, 16'd0);
    send_item(FUNC_QUERY, 8'd10, 3'd0, 16'd0);
    drain_results();

    // Duration lowered mid-blend, then zero duration
    send_item(FUNC_SET_TARGET, 8'd1, 3'd4, 16'd0);
    send_item(FUNC_TICK, 8'd1, 3'd0, 16'd1000);
    drain_results();
    write_reg(REG_BLEND_DURATION, 24'd500);
    send_item(FUNC_QUERY, 8'd1, 3'd0, 16'd0);
    send_item(FUNC_TICK, 8'd1, 3'd0, 16'd0);
    drain_results();
    write_reg(REG_BLEND_DURATION, 24'd0);
    send_item(FUNC_SET_TARGET, 8'd2, 3'd6, 16'd0);
    send_item(FUNC_TICK, 8'd2, 3'd0, 16'd0);
    drain_results();

    // Random phases across settings; the sender pauses for a drain after each
    write_reg(REG_BLEND_DURATION, 24'd1);
    random_phase(120, 16'd4);
    write_reg(REG_BLEND_DURATION, 24'hFFFFFF);
    random_phase(120, 16'hFFFF);
    write_reg(REG_ENABLE_BLENDING, 1'b0);
    write_reg(REG_BLEND_DURATION, 24'd3000);
    random_phase(120, 16'd2000);
    write_reg(REG_ENABLE_BLENDING, 1'b1);
    write_reg(REG_BLEND_DURATION, 24'hABCDEF);
    random_phase(120, 16'hFFFF);

    // Receiver holds off while the sender keeps offering beats
    write_reg(REG_BLEND_DURATION, 24'd3000);
    hold_sink = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      random_phase(200, 16'd1500);
    join

    write_reg(REG_BLEND_DURATION, 24'd250000);
    random_phase(200, 16'hFFFF);
    calm_mode = 1'b1;
    write_reg(REG_BLEND_DURATION, 24'd5000);
    random_phase(170, 16'd3000);

    $display("sent %0d items over %0d random phases plus directed cases,", items_sent, phases_run);
    $display("covering blend on/off, durations 0 to max, stalls and a full back-pressure stretch");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lbt_pkg.sv
rtl/lbt_ram.sv
rtl/lbt_front.sv
rtl/lbt_weight.sv
rtl/lbt_back.sv
rtl/lod_blend_tracker_unit.sv
tb/sv/lbt_result_checker.sv
tb/sv/tb_lod_blend_tracker_unit.sv
